[src/mecanum_wheel_incremental_pid_defines.svh]
// Assertion macros shared by the mecanum PID checker.
// No dependencies; expects aclk and aresetn in the including scope.
`ifndef MECANUM_WHEEL_INCREMENTAL_PID_DEFINES_SVH
`define MECANUM_WHEEL_INCREMENTAL_PID_DEFINES_SVH

// same-cycle implication
`define MWIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MWIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mwip_pkg.sv]
// Package for the mecanum four-wheel incremental PID block: widths, register
// indexes, reset values, shared structs and the gain-term truncation helper.
// No dependencies.
package mwip_pkg;

    localparam int NUM_WHEELS     = 4;
    localparam int CMD_W          = 14;
    localparam int GOAL_W         = 16;
    localparam int ERR_W          = 17;
    localparam int DP_W           = ERR_W + 1;
    localparam int DD_W           = ERR_W + 2;
    localparam int GAIN_W         = 16;
    localparam int LIM_W          = 14;
    localparam int DRV_W          = 15;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int TRUNC_BIAS     = (1 << GAIN_FRAC_BITS) - 1;
    localparam int PROD_W         = GAIN_W + 1 + DD_W;
    localparam int TERM_W         = PROD_W - GAIN_FRAC_BITS;
    localparam int SUM_W          = TERM_W + 2;
    localparam int ACC_W          = SUM_W + 1;

    localparam int IN_FIELDS      = 3 + NUM_WHEELS;
    localparam int IN_TDATA_W     = ((IN_FIELDS * CMD_W + 7) / 8) * 8;
    localparam int LANE_OUT_W     = LIM_W + 1;
    localparam int OUT_TDATA_W    = ((NUM_WHEELS * LANE_OUT_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DUTY_LIMIT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COAST_ENABLE = 3'd4;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd5120;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd15360;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;
    localparam logic [LIM_W-1:0]  DUTY_LIMIT_RST = 14'd9990;
    localparam logic              COAST_EN_RST   = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [LIM_W-1:0]  lim;
        logic              coast_en;
    } cfg_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic coast_in;
        logic coast_s3;
    } lane_ctl_t;

    typedef logic [NUM_WHEELS-1:0][GOAL_W-1:0] goal_vec_t;
    typedef logic [NUM_WHEELS-1:0][DRV_W-1:0]  drv_vec_t;

    // product / 2^F, rounded toward zero
    function automatic logic signed [TERM_W-1:0] trunc_term(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] b;
        b = p + (p[PROD_W-1] ? PROD_W'(TRUNC_BIAS) : PROD_W'(0));
        return b[PROD_W-1:GAIN_FRAC_BITS];
    endfunction

endpackage

[src/mecanum_wheel_incremental_pid.sv]
// Four-wheel mecanum velocity-form PID. One transfer in gives one transfer out; a
// new item is taken every cycle unless a full pipeline is stalled by m_tready low,
// and each passes through error, gain products, truncated PID sum and clamped drive
// update with the output register: the four-stage pipeline of all four wheel lanes.
// Each stage holds its item while the next is full, so while a result waits up to
// three more items are taken before s_tready drops. Config writes take effect at
// once and belong in idle periods.
module mecanum_wheel_incremental_pid (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // fwd_cmd, side_cmd, rot_cmd, speed_front_left, speed_front_right,
    // speed_rear_left, speed_rear_right (14 bits each), zero pad
    input  logic [mwip_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // duty_front_left, rev_front_left, duty_front_right, rev_front_right,
    // duty_rear_left, rev_rear_left, duty_rear_right, rev_rear_right, zero pad
    output logic [mwip_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // coasting
    output logic                                 m_tuser,
    input  logic                                 cfg_wr_en,
    input  logic [mwip_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mwip_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int CMD_W = mwip_pkg::CMD_W;

    mwip_pkg::cfg_t      cfg_reg;
    mwip_pkg::lane_ctl_t ctl;
    mwip_pkg::goal_vec_t goal;
    mwip_pkg::drv_vec_t  drv_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic c1_reg, c2_reg, c3_reg;
    logic free1, free2, free3, free4;
    logic coast_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp       <= mwip_pkg::PROP_GAIN_RST;
            cfg_reg.ki       <= mwip_pkg::INTEG_GAIN_RST;
            cfg_reg.kd       <= mwip_pkg::DERIV_GAIN_RST;
            cfg_reg.lim      <= mwip_pkg::DUTY_LIMIT_RST;
            cfg_reg.coast_en <= mwip_pkg::COAST_EN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mwip_pkg::REG_PROP_GAIN: begin
                    cfg_reg.kp <= cfg_wdata;
                end
                mwip_pkg::REG_INTEG_GAIN: begin
                    cfg_reg.ki <= cfg_wdata;
                end
                mwip_pkg::REG_DERIV_GAIN: begin
                    cfg_reg.kd <= cfg_wdata;
                end
                mwip_pkg::REG_DUTY_LIMIT: begin
                    cfg_reg.lim <= cfg_wdata[mwip_pkg::LIM_W-1:0];
                end
                mwip_pkg::REG_COAST_ENABLE: begin
                    cfg_reg.coast_en <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    mwip_kin u_kin (
        .fwd_cmd  (s_tdata[0*CMD_W +: CMD_W]),
        .side_cmd (s_tdata[1*CMD_W +: CMD_W]),
        .rot_cmd  (s_tdata[2*CMD_W +: CMD_W]),
        .coast_en (cfg_reg.coast_en),
        .goal     (goal),
        .coast    (coast_in)
    );

    // a stage can take a new item when empty or when its item moves on
    always_comb begin
        free4    = !v4_reg || m_tready;
        free3    = !v3_reg || free4;
        free2    = !v2_reg || free3;
        free1    = !v1_reg || free2;
        s_tready = free1;

        ctl.ld1      = free1 && s_tvalid;
        ctl.ld2      = free2 && v1_reg;
        ctl.ld3      = free3 && v2_reg;
        ctl.ld4      = free4 && v3_reg;
        ctl.coast_in = coast_in;
        ctl.coast_s3 = c3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (free1) v1_reg <= s_tvalid;
            if (free2) v2_reg <= v1_reg;
            if (free3) v3_reg <= v2_reg;
            if (free4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld1) c1_reg <= coast_in;
        if (ctl.ld2) c2_reg <= c1_reg;
        if (ctl.ld3) c3_reg <= c2_reg;
    end

    for (genvar i = 0; i < mwip_pkg::NUM_WHEELS; i++) begin : g_lane
        mwip_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .cfg      (cfg_reg),
            .goal     (goal[i]),
            .speed    (s_tdata[(3 + i)*CMD_W +: CMD_W]),
            .drv_next (drv_next[i])
        );
    end

    mwip_merge u_merge (
        .aclk  (aclk),
        .load  (ctl.ld4),
        .drv   (drv_next),
        .coast (c3_reg),
        .tdata (m_tdata),
        .tuser (m_tuser)
    );

    assign m_tvalid = v4_reg;

endmodule

[src/mwip_kin.sv]
// Mecanum X-type inverse kinematics and zero-goal coast detection.
// Depends on mwip_pkg.
module mwip_kin (
    input  logic [mwip_pkg::CMD_W-1:0] fwd_cmd,
    input  logic [mwip_pkg::CMD_W-1:0] side_cmd,
    input  logic [mwip_pkg::CMD_W-1:0] rot_cmd,
    input  logic                       coast_en,
    output mwip_pkg::goal_vec_t        goal,
    output logic                       coast
);

    logic signed [mwip_pkg::GOAL_W-1:0] f, s, r;

    always_comb begin
        f = mwip_pkg::GOAL_W'($signed(fwd_cmd));
        s = mwip_pkg::GOAL_W'($signed(side_cmd));
        r = mwip_pkg::GOAL_W'($signed(rot_cmd));
        goal[0] = f - s - r;
        goal[1] = f + s + r;
        goal[2] = f + s - r;
        goal[3] = f - s + r;
        coast = coast_en && (goal == '0);
    end

endmodule

[src/mwip_lane.sv]
// One wheel's velocity-form PID: error history, gain products, truncated sum,
// and the clamped drive value accumulator. Depends on mwip_pkg.
module mwip_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mwip_pkg::lane_ctl_t         ctl,
    input  mwip_pkg::cfg_t              cfg,
    input  logic [mwip_pkg::GOAL_W-1:0] goal,
    input  logic [mwip_pkg::CMD_W-1:0]  speed,
    output logic [mwip_pkg::DRV_W-1:0]  drv_next
);

    localparam int ERR_W  = mwip_pkg::ERR_W;
    localparam int DP_W   = mwip_pkg::DP_W;
    localparam int DD_W   = mwip_pkg::DD_W;
    localparam int PROD_W = mwip_pkg::PROD_W;
    localparam int SUM_W  = mwip_pkg::SUM_W;
    localparam int ACC_W  = mwip_pkg::ACC_W;
    localparam int DRV_W  = mwip_pkg::DRV_W;
    localparam int GAIN_W = mwip_pkg::GAIN_W;
    localparam int LIM_W  = mwip_pkg::LIM_W;

    logic signed [ERR_W-1:0]  e1_reg, e2_reg;
    logic signed [ERR_W-1:0]  s1_e_reg;
    logic signed [DP_W-1:0]   s1_dp_reg;
    logic signed [DD_W-1:0]   s1_dd_reg;
    logic signed [PROD_W-1:0] pp_reg, pi_reg, pd_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DRV_W-1:0]  drv_reg;

    logic signed [ERR_W-1:0]  e;
    logic signed [DP_W-1:0]   dp;
    logic signed [DD_W-1:0]   dd;
    logic signed [GAIN_W:0]   kp_s, ki_s, kd_s;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [ACC_W-1:0]  acc, lim_pos, lim_neg, clamped;

    always_comb begin
        e  = ERR_W'($signed(goal)) - ERR_W'($signed(speed));
        dp = DP_W'(e) - DP_W'(e1_reg);
        dd = DD_W'(e) - (DD_W'(e1_reg) <<< 1) + DD_W'(e2_reg);
    end

    // history follows every transfer in order, so it is updated at entry (cleared on coast)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_reg <= '0;
            e2_reg <= '0;
        end else if (ctl.ld1) begin
            if (ctl.coast_in) begin
                e1_reg <= '0;
                e2_reg <= '0;
            end else begin
                e1_reg <= e;
                e2_reg <= e1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            s1_e_reg  <= e;
            s1_dp_reg <= dp;
            s1_dd_reg <= dd;
        end
    end

    always_comb begin
        kp_s = $signed({1'b0, cfg.kp});
        ki_s = $signed({1'b0, cfg.ki});
        kd_s = $signed({1'b0, cfg.kd});
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld2) begin
            pp_reg <= kp_s * s1_dp_reg;
            pi_reg <= ki_s * s1_e_reg;
            pd_reg <= kd_s * s1_dd_reg;
        end
    end

    always_comb begin
        sum_next = SUM_W'(mwip_pkg::trunc_term(pp_reg))
                 + SUM_W'(mwip_pkg::trunc_term(pi_reg))
                 + SUM_W'(mwip_pkg::trunc_term(pd_reg));
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld3) begin
            sum_reg <= sum_next;
        end
    end

    always_comb begin
        acc     = ACC_W'(drv_reg) + ACC_W'(sum_reg);
        lim_pos = $signed({{(ACC_W - LIM_W){1'b0}}, cfg.lim});
        lim_neg = -lim_pos;
        if (acc > lim_pos) begin
            clamped = lim_pos;
        end else if (acc < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = acc;
        end
        drv_next = ctl.coast_s3 ? '0 : clamped[DRV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drv_reg <= '0;
        end else if (ctl.ld4) begin
            drv_reg <= drv_next;
        end
    end

endmodule

[src/mwip_merge.sv]
// Output register: turns the four lanes' drive values into magnitude and
// direction and packs them with the coast flag. Depends on mwip_pkg.
module mwip_merge (
    input  logic                             aclk,
    input  logic                             load,
    input  mwip_pkg::drv_vec_t               drv,
    input  logic                             coast,
    output logic [mwip_pkg::OUT_TDATA_W-1:0] tdata,
    output logic                             tuser
);

    localparam int LANE_OUT_W = mwip_pkg::LANE_OUT_W;
    localparam int LIM_W      = mwip_pkg::LIM_W;
    localparam int DRV_W      = mwip_pkg::DRV_W;

    logic [mwip_pkg::OUT_TDATA_W-1:0] tdata_reg, tdata_next;
    logic                             tuser_reg;
    logic signed [DRV_W-1:0]          v, mag;

    always_comb begin
        tdata_next = '0;
        v   = '0;
        mag = '0;
        for (int i = 0; i < mwip_pkg::NUM_WHEELS; i++) begin
            v   = $signed(drv[i]);
            mag = v[DRV_W-1] ? -v : v;
            tdata_next[i*LANE_OUT_W +: LIM_W] = mag[LIM_W-1:0];
            tdata_next[i*LANE_OUT_W + LIM_W]  = v[DRV_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= tdata_next;
            tuser_reg <= coast;
        end
    end

    assign tdata = tdata_reg;
    assign tuser = tuser_reg;

endmodule

[src/mwip_checker.sv]
// Port-level checks on the result channel of the mecanum PID block, bound to the
// top level. Depends on mwip_pkg and mecanum_wheel_incremental_pid_defines.svh.
`include "mecanum_wheel_incremental_pid_defines.svh"

module mwip_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mwip_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tuser
);

    `MWIP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result transfer changed")
    `MWIP_ASSERT_NOW(a_coast_zero, m_tvalid && m_tuser, m_tdata == '0, "coast result carries nonzero drive")
    `MWIP_ASSERT_NOW(a_rev_nonzero, m_tvalid, !((m_tdata[14] && m_tdata[13:0] == 14'd0) || (m_tdata[29] && m_tdata[28:15] == 14'd0) || (m_tdata[44] && m_tdata[43:30] == 14'd0) || (m_tdata[59] && m_tdata[58:45] == 14'd0)), "reverse flag on zero duty")
    `MWIP_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[63:60] == 4'd0, "pad bits of result not zero")

endmodule

bind mecanum_wheel_incremental_pid mwip_checker u_mwip_checker (.*);
